// ===== rtl/core/assert_macros.svh =====
// assert_macros.svh: concurrent assertion macros for the RTL.
// No dependencies; taken in by `include in the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is low.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed: label");

// Same check, but with the reset condition active high.
`define ASSERT_CLK_DIS(label, clk, dis, prop) \
    label: assert property (@(posedge clk) disable iff (dis) (prop)) \
        else $error("assertion failed: label");

`endif

// ===== rtl/core/tspd_pkg.sv =====
// tspd_pkg: widths, reset values and register indexes of the pass detector.
// No dependencies; imported by three_sensor_pass_detector.
package tspd_pkg;

    localparam int CNT_W  = 8;
    localparam int TIME_W = 32;
    localparam int NUM_SENSORS = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    // Offset in the "count exceeds pass count minus margin" gates.
    localparam logic [CNT_W:0] GATE_MARGIN = (CNT_W + 1)'(3);

    localparam logic [CNT_W-1:0]  PASS_FIRST_RST  = CNT_W'(5);
    localparam logic [CNT_W-1:0]  PASS_SECOND_RST = CNT_W'(6);
    localparam logic [CNT_W-1:0]  PASS_THIRD_RST  = CNT_W'(4);
    localparam logic [TIME_W-1:0] TIMEOUT_RST     = TIME_W'(4500);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PASS_FIRST  = 2'd0,
        CFG_PASS_SECOND = 2'd1,
        CFG_PASS_THIRD  = 2'd2,
        CFG_TIMEOUT     = 2'd3
    } cfg_idx_t;

endpackage

// ===== rtl/core/three_sensor_pass_detector.sv =====
// three_sensor_pass_detector: counts sensor hits and flags completed passes.
// Depends on tspd_pkg and assert_macros.svh.
//
//  channel   | ports                                   | direction
//  ----------+-----------------------------------------+----------
//  poll      | s_valid s_ready s_hit_* s_now_ms         | in
//  result    | m_valid m_ready m_pass_seen              | out
//  config    | cfg_wr_en cfg_addr cfg_wdata             | in
//
// One request per cycle unless the result side stalls; an accepted poll is
// held in the input register, then the counter update loads the result reg.
// Counters and stamps update in the same cycle the result register loads.
// Reset clears counters, stamps, valid flags and restores register defaults.
// A stalled result holds the pipeline; the input register still fills once.
`include "assert_macros.svh"

module three_sensor_pass_detector
    import tspd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // poll channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_hit_first,
    input  logic                  s_hit_second,
    input  logic                  s_hit_third,
    input  logic [TIME_W-1:0]     s_now_ms,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_pass_seen,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration registers
    logic [CNT_W-1:0]  pass0_reg, pass1_reg, pass2_reg;
    logic [TIME_W-1:0] timeout_reg;

    // input stage
    logic                   in_valid_reg;
    logic [NUM_SENSORS-1:0] hit_reg;
    logic [TIME_W-1:0]      now_reg;

    // state and result
    logic [CNT_W-1:0]  cnt_reg  [NUM_SENSORS];
    logic [CNT_W-1:0]  cnt_next [NUM_SENSORS];
    logic [TIME_W-1:0] time_reg [NUM_SENSORS];
    logic [TIME_W-1:0] time_next[NUM_SENSORS];
    logic              m_valid_reg, pass_reg;
    logic              pass_next;

    logic advance;
    logic [CNT_W-1:0]  c0a, c1a, c2a;
    logic [CNT_W-1:0]  c_sub [NUM_SENSORS];
    logic [TIME_W-1:0] t_hit [NUM_SENSORS];
    logic              ok1, ok2;
    logic [NUM_SENSORS*CNT_W-1:0] cnt_flat;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        bump = (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
    endfunction

    // handshake: output slot frees when empty or taken
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_pass_seen = pass_reg;
    assign cnt_flat = {cnt_reg[2], cnt_reg[1], cnt_reg[0]};

    // hit counting with gating on the already updated counters
    always_comb begin
        c0a = hit_reg[0] ? bump(cnt_reg[0]) : cnt_reg[0];
        ok1 = hit_reg[1] && (({1'b0, c0a} + GATE_MARGIN) > {1'b0, pass0_reg});
        c1a = ok1 ? bump(cnt_reg[1]) : cnt_reg[1];
        ok2 = hit_reg[2] && (c0a >= pass0_reg)
              && (({1'b0, c1a} + GATE_MARGIN) > {1'b0, pass1_reg});
        c2a = ok2 ? bump(cnt_reg[2]) : cnt_reg[2];

        t_hit[0] = hit_reg[0] ? now_reg : time_reg[0];
        t_hit[1] = ok1 ? now_reg : time_reg[1];
        t_hit[2] = ok2 ? now_reg : time_reg[2];

        // pass detection and pass-count removal
        pass_next = (c0a >= pass0_reg) && (c1a >= pass1_reg) && (c2a >= pass2_reg);
        c_sub[0] = pass_next ? c0a - pass0_reg : c0a;
        c_sub[1] = pass_next ? c1a - pass1_reg : c1a;
        c_sub[2] = pass_next ? c2a - pass2_reg : c2a;

        // idle timeout clears and restamps
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if ((now_reg - t_hit[i]) > timeout_reg) begin
                cnt_next[i]  = '0;
                time_next[i] = now_reg;
            end else begin
                cnt_next[i]  = c_sub[i];
                time_next[i] = t_hit[i];
            end
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pass0_reg    <= PASS_FIRST_RST;
            pass1_reg    <= PASS_SECOND_RST;
            pass2_reg    <= PASS_THIRD_RST;
            timeout_reg  <= TIMEOUT_RST;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                cnt_reg[i]  <= '0;
                time_reg[i] <= '0;
            end
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                m_valid_reg <= 1'b1;
                for (int i = 0; i < NUM_SENSORS; i++) begin
                    cnt_reg[i]  <= cnt_next[i];
                    time_reg[i] <= time_next[i];
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_PASS_FIRST:  pass0_reg   <= cfg_wdata[CNT_W-1:0];
                    CFG_PASS_SECOND: pass1_reg   <= cfg_wdata[CNT_W-1:0];
                    CFG_PASS_THIRD:  pass2_reg   <= cfg_wdata[CNT_W-1:0];
                    CFG_TIMEOUT:     timeout_reg <= cfg_wdata[TIME_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hit_reg <= {s_hit_third, s_hit_second, s_hit_first};
            now_reg <= s_now_ms;
        end
        if (advance) begin
            pass_reg <= pass_next;
        end
    end

    // checks
    `ASSERT_CLK(a_adv_gives_result, aclk, aresetn, advance |=> m_valid_reg)
    `ASSERT_CLK(a_state_holds, aclk, aresetn, !advance |=> $stable(cnt_flat))
    `ASSERT_CLK(a_stall_cause, aclk, aresetn, !s_ready |-> in_valid_reg && m_valid_reg && !m_ready)

endmodule

// ===== tb/sv/three_sensor_pass_detector_tb.sv =====
// three_sensor_pass_detector_tb: self-checking bench for the three-sensor pass detector.
// Needs tspd_pkg and three_sensor_pass_detector; checks each pass_seen against a local model or a hand-typed value.
module three_sensor_pass_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tspd_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT = 36;
    localparam int MAX_REPORTS = 40;
    localparam int N_DIRECTED = 19;
    localparam int N_RANDOM_PHASES = 8;

    // one directed poll; hits is {third, second, first}
    typedef struct packed {
        logic [2:0]        hits;
        logic [TIME_W-1:0] now;
        logic              typed;   // expected pass filled in by hand
        logic              pass;
    } poll_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_hit_first = 1'b0;
    logic                  s_hit_second = 1'b0;
    logic                  s_hit_third = 1'b0;
    logic [TIME_W-1:0]     s_now_ms = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_pass_seen;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_PASS_FIRST;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // local copy of counters, stamps and registers
    logic [CNT_W-1:0]  hit_cnt [NUM_SENSORS];
    logic [TIME_W-1:0] hit_stamp [NUM_SENSORS];
    logic [CNT_W-1:0]  need_cnt [NUM_SENSORS];
    logic [TIME_W-1:0] idle_limit;

    logic pass_expected [$];
    logic want_pass;
    bit   steady = 1'b0;
    int   mismatches = 0;
    int   polls_sent = 0;
    int   passes_seen = 0;
    int   cfg_writes = 0;
    int   cycles = 0;

    poll_row_t dir_rows [N_DIRECTED] = '{
        '{3'b000, 32'h0000_0000, 1'b1, 1'b0},   // idle poll right after reset
        '{3'b001, 32'd100,       1'b1, 1'b0},
        '{3'b111, 32'd200,       1'b1, 1'b0},   // second and third still gated
        '{3'b111, 32'd300,       1'b0, 1'b0},
        '{3'b111, 32'd400,       1'b0, 1'b0},
        '{3'b111, 32'd500,       1'b0, 1'b0},
        '{3'b111, 32'd600,       1'b0, 1'b0},
        '{3'b111, 32'd700,       1'b0, 1'b0},
        '{3'b111, 32'd800,       1'b0, 1'b0},
        '{3'b111, 32'd900,       1'b0, 1'b0},   // all three reach their counts
        '{3'b000, 32'd5400,      1'b0, 1'b0},   // elapsed equals timeout: kept
        '{3'b000, 32'd5401,      1'b0, 1'b0},   // one past timeout: cleared
        '{3'b010, 32'd5500,      1'b0, 1'b0},   // second alone is gated off
        '{3'b100, 32'd5600,      1'b0, 1'b0},   // third alone is gated off
        '{3'b001, 32'hFFFF_FFF0, 1'b0, 1'b0},
        '{3'b001, 32'h0000_0010, 1'b0, 1'b0},   // time wraps past zero
        '{3'b000, 32'h8000_0000, 1'b0, 1'b0},
        '{3'b111, 32'hFFFF_FFFF, 1'b0, 1'b0},
        '{3'b000, 32'h0000_0000, 1'b0, 1'b0}
    };

    three_sensor_pass_detector uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hit_first  (s_hit_first),
        .s_hit_second (s_hit_second),
        .s_hit_third  (s_hit_third),
        .s_now_ms     (s_now_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pass_seen  (m_pass_seen),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    // Advance the local counters by one poll; returns the pass flag.
    function automatic logic score_poll(input logic [2:0] hits, input logic [TIME_W-1:0] now);
        logic passed;
        logic [TIME_W-1:0] idle;
        passed = 1'b0;
        if (hits[0]) begin
            hit_stamp[0] = now;
            hit_cnt[0] = sat_inc(hit_cnt[0]);
        end
        // thresholds are signed: small pass counts leave the gate open
        if (hits[1] && int'(hit_cnt[0]) > int'(need_cnt[0]) - int'(GATE_MARGIN)) begin
            hit_stamp[1] = now;
            hit_cnt[1] = sat_inc(hit_cnt[1]);
        end
        if (hits[2] && hit_cnt[0] >= need_cnt[0] &&
            int'(hit_cnt[1]) > int'(need_cnt[1]) - int'(GATE_MARGIN)) begin
            hit_stamp[2] = now;
            hit_cnt[2] = sat_inc(hit_cnt[2]);
        end
        if (hit_cnt[0] >= need_cnt[0] && hit_cnt[1] >= need_cnt[1] &&
            hit_cnt[2] >= need_cnt[2]) begin
            passed = 1'b1;
            for (int i = 0; i < NUM_SENSORS; i++)
                hit_cnt[i] = hit_cnt[i] - need_cnt[i];
        end
        // stale counters clear and restamp; elapsed wraps modulo 2^32
        for (int i = 0; i < NUM_SENSORS; i++) begin
            idle = now - hit_stamp[i];
            if (idle > idle_limit) begin
                hit_cnt[i] = '0;
                hit_stamp[i] = now;
            end
        end
        return passed;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_PASS_FIRST:  need_cnt[0] = val[CNT_W-1:0];
            CFG_PASS_SECOND: need_cnt[1] = val[CNT_W-1:0];
            CFG_PASS_THIRD:  need_cnt[2] = val[CNT_W-1:0];
            CFG_TIMEOUT:     idle_limit = val[TIME_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Stop sending and wait until every pending result has come back.
    task automatic settle();
        s_valid <= 1'b0;
        while (pass_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Present one poll, hold it until taken, then log its expected result.
    task automatic send_poll(input logic [2:0] hits, input logic [TIME_W-1:0] now,
                             input logic typed, input logic typed_pass);
        logic predicted;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_hit_first <= hits[0];
        s_hit_second <= hits[1];
        s_hit_third <= hits[2];
        s_now_ms <= now;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        predicted = score_poll(hits, now);
        pass_expected.push_back(typed ? typed_pass : predicted);
        polls_sent++;
    endtask

    // One configuration followed by a run of random polls.
    task automatic run_phase(input logic [CNT_W-1:0] pc0, input logic [CNT_W-1:0] pc1,
                             input logic [CNT_W-1:0] pc2, input logic [TIME_W-1:0] tmo,
                             input int n_polls, input int pct0, input int pct1,
                             input int pct2, input int pause_at);
        logic [TIME_W-1:0] now_t;
        logic [TIME_W-1:0] span;
        logic [2:0] hits;
        int r;
        settle();
        write_reg(CFG_PASS_FIRST, CFG_DATA_W'(pc0));
        write_reg(CFG_PASS_SECOND, CFG_DATA_W'(pc1));
        write_reg(CFG_PASS_THIRD, CFG_DATA_W'(pc2));
        write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
        cfg_wr_en <= 1'b0;
        now_t = $urandom;
        span = (tmo < 9) ? 3 : tmo / 3;
        for (int i = 0; i < n_polls; i++) begin
            if (i == pause_at)
                settle();
            // mostly small steps, some landing right on a timeout edge, a few jumps
            r = $urandom_range(99);
            if (r < 84)
                now_t = now_t + $urandom_range(span);
            else if (r < 95)
                now_t = hit_stamp[$urandom_range(NUM_SENSORS - 1)] + tmo + $urandom_range(1);
            else
                now_t = $urandom;
            hits[0] = $urandom_range(99) < pct0;
            hits[1] = $urandom_range(99) < pct1;
            hits[2] = $urandom_range(99) < pct2;
            send_poll(hits, now_t, 1'b0, 1'b0);
        end
    endtask

    task automatic note_mismatch(input string what, input logic exp_v, input logic act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected %0b actual %0b", $time, what, exp_v, act_v);
    endtask

    // Result side: check each accepted result, then pick next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pass_expected.size() == 0) begin
                note_mismatch("pass_seen with no request pending", 1'bx, m_pass_seen);
            end else begin
                want_pass = pass_expected.pop_front();
                if (m_pass_seen !== want_pass)
                    note_mismatch("pass_seen", want_pass, m_pass_seen);
                if (m_pass_seen === 1'b1)
                    passes_seen++;
            end
        end
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL three_sensor_pass_detector");
            $finish;
        end
    end

    // Stimulus
    initial begin
        logic [CNT_W-1:0] p0;
        logic [CNT_W-1:0] p1;
        logic [CNT_W-1:0] p2;
        logic [TIME_W-1:0] tmo;
        int r;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            hit_cnt[i] = '0;
            hit_stamp[i] = '0;
        end
        need_cnt[0] = PASS_FIRST_RST;
        need_cnt[1] = PASS_SECOND_RST;
        need_cnt[2] = PASS_THIRD_RST;
        idle_limit = TIMEOUT_RST;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed polls on reset register values
        for (int k = 0; k < N_DIRECTED; k++)
            send_poll(dir_rows[k].hits, dir_rows[k].now, dir_rows[k].typed, dir_rows[k].pass);

        // register extremes: smallest counts with zero timeout, then all maxed (saturation)
        run_phase(8'd1, 8'd1, 8'd1, 32'd0, 60, 70, 70, 70, -1);
        run_phase(8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF, 330, 97, 90, 90, -1);
        // counts below the gate margin keep the signed gates open
        run_phase(8'd2, 8'd1, 8'd2, 32'd1000, 150, 75, 65, 65, -1);
        // zero pass counts are out of range but still obeyed
        run_phase(8'd0, 8'd3, 8'd0, 32'd500, 80, 60, 60, 60, -1);
        run_phase(8'd0, 8'd0, 8'd0, 32'd100, 30, 50, 50, 50, -1);

        for (int ph = 0; ph < N_RANDOM_PHASES; ph++) begin
            r = $urandom_range(99);
            p0 = CNT_W'((r < 85) ? $urandom_range(8, 1) : $urandom_range(255, 1));
            p1 = CNT_W'((r < 85) ? $urandom_range(8, 1) : $urandom_range(255, 1));
            p2 = CNT_W'((r < 85) ? $urandom_range(8, 1) : $urandom_range(255, 1));
            r = $urandom_range(99);
            if (r < 80)
                tmo = $urandom_range(3000, 20);
            else if (r < 90)
                tmo = $urandom_range(5);
            else
                tmo = $urandom;
            steady = (ph == 3);
            run_phase(p0, p1, p2, tmo, 164, 70, 60, 60, (ph == 1) ? 82 : -1);
        end
        steady = 1'b0;
        settle();

        $display("Ran %0d polls across %0d register writes; %0d passes flagged.",
                 polls_sent, cfg_writes, passes_seen);
        $display("Covered gate margins, zero and maximum counts, saturation, timeout edges, wrap.");
        if (mismatches == 0) begin
            $display("PASS three_sensor_pass_detector");
        end else begin
            $display("FAIL three_sensor_pass_detector");
        end
        $finish;
    end

endmodule
